>>> rtl/core/dltq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants for the delta-list timeout queue: list sizing,
// field widths, result kinds and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package dltq_pkg;

  // List sizing
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned MaxOut     = 16;   // expiries emitted per tick at most
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned EmitW      = $clog2(MaxOut + 1);

  // Field widths
  localparam int unsigned DeltaW  = 15;
  localparam int unsigned HandleW = 16;
  localparam int unsigned KindW   = 2;

  // Input command codes
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_NONE    = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_DONE,
    S_INS_FULL,
    S_TICK_DEC,
    S_TICK_EXP
  } dltq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  load;    // capture the accepted item, rewind index
    logic  walk;    // subtract current delta, step index
    logic  place;   // insert at index, shift tail down
    logic  step;    // step index only (zero delta during tick search)
    logic  dec;     // decrement delta at index
    logic  pop;     // drop head, shift list up
    logic  emit;    // load the output register
    kind_t kind;
    logic  last;
  } dltq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;        // list holds QueueDepth entries
    logic idx_lt_cnt;  // index points at a valid entry
    logic cur_le_t;    // delta at index <= remaining insert time
    logic cur_zero;    // delta at index is zero
    logic head_exp;    // head entry present and expired
    logic last_exp;    // head is the final expiry of this tick
    logic blocked;     // current tick is blocked
    logic out_free;    // output register can take a result
  } dltq_sts_t;

endpackage : dltq_pkg
`default_nettype wire

>>> rtl/core/dltq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for the timeout queue: walks the list for inserts, searches for
// the first nonzero delta on ticks and drains expired heads one per transfer.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_cmd,
  output logic                      in_stall,
  input  dltq_pkg::dltq_sts_t       sts,
  output dltq_pkg::dltq_cmd_t       cmd
);
  import dltq_pkg::*;

  dltq_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_INSERT) ? S_INS_WALK : S_TICK_DEC;
        end
      end
      S_INS_WALK: begin
        if (sts.full) begin
          state_nxt = S_INS_FULL;
        end else if (!(sts.idx_lt_cnt && sts.cur_le_t)) begin
          state_nxt = S_INS_DONE;
        end
      end
      S_INS_DONE, S_INS_FULL: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK_DEC: begin
        if (!sts.idx_lt_cnt || !sts.cur_zero) begin
          state_nxt = S_TICK_EXP;
        end
      end
      S_TICK_EXP: begin
        if (sts.out_free) begin
          if (sts.blocked || !sts.head_exp || sts.last_exp) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = KIND_NONE;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_INS_WALK: begin
        if (!sts.full) begin
          if (sts.idx_lt_cnt && sts.cur_le_t) begin
            cmd.walk = 1'b1;
          end else begin
            cmd.place = 1'b1;
          end
        end
      end
      S_INS_DONE: begin
        cmd.emit = sts.out_free;
        cmd.kind = KIND_DONE;
        cmd.last = 1'b1;
      end
      S_INS_FULL: begin
        cmd.emit = sts.out_free;
        cmd.kind = KIND_FULL;
        cmd.last = 1'b1;
      end
      S_TICK_DEC: begin
        if (sts.idx_lt_cnt) begin
          if (sts.cur_zero) begin
            cmd.step = 1'b1;
          end else begin
            cmd.dec = 1'b1;
          end
        end
      end
      S_TICK_EXP: begin
        cmd.emit = sts.out_free;
        if (!sts.blocked && sts.head_exp) begin
          cmd.kind = KIND_EXPIRED;
          cmd.last = sts.last_exp;
          cmd.pop  = sts.out_free;
        end else begin
          cmd.kind = KIND_NONE;
          cmd.last = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : dltq_ctrl
`default_nettype wire

>>> rtl/core/dltq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_datapath
// Entry registers of the delta list, the walk index and remaining time, and
// the output register. Acts on commands from the sequencer.
// ----------------------------------------------------------------------------
module dltq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tick_blocked,
  input  wire logic [dltq_pkg::DeltaW-1:0]   in_delay_ticks,
  input  wire logic [dltq_pkg::HandleW-1:0]  in_handle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dltq_pkg::KindW-1:0]         out_kind,
  output logic [dltq_pkg::HandleW-1:0]       out_expired_handle,
  output logic                               out_last,
  input  dltq_pkg::dltq_cmd_t                cmd,
  output dltq_pkg::dltq_sts_t                sts
);
  import dltq_pkg::*;

  // List storage
  logic [DeltaW-1:0]  delta_r   [QueueDepth];
  logic [DeltaW-1:0]  delta_nxt [QueueDepth];
  logic [HandleW-1:0] handle_r  [QueueDepth];
  logic [HandleW-1:0] handle_nxt[QueueDepth];
  logic [CntW-1:0]    count_r, count_nxt;

  // Walk state and captured item
  logic [CntW-1:0]    idx_r, idx_nxt;
  logic [EmitW-1:0]   emit_cnt_r, emit_cnt_nxt;
  logic [DeltaW-1:0]  t_r, t_nxt;
  logic [HandleW-1:0] hnd_r;
  logic               blocked_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r;
  logic [HandleW-1:0] out_handle_r;
  logic               out_last_r;

  logic [DeltaW-1:0]  cur_delta;
  logic               out_free;

  assign cur_delta = delta_r[idx_r[IdxW-1:0]];
  assign out_free  = !out_valid_r || !out_stall;

  // Status back to the sequencer
  always_comb begin
    sts.full       = (count_r == CntW'(QueueDepth));
    sts.idx_lt_cnt = (idx_r < count_r);
    sts.cur_le_t   = (cur_delta <= t_r);
    sts.cur_zero   = (cur_delta == '0);
    sts.head_exp   = (count_r != '0) && (delta_r[0] == '0);
    sts.last_exp   = (count_r == CntW'(1)) || (delta_r[1] != '0) ||
                     (emit_cnt_r == EmitW'(MaxOut - 1));
    sts.blocked    = blocked_r;
    sts.out_free   = out_free;
  end

  // Walk index, remaining time and expiry count
  always_comb begin
    idx_nxt      = idx_r;
    t_nxt        = t_r;
    emit_cnt_nxt = emit_cnt_r;
    if (cmd.load) begin
      idx_nxt      = '0;
      t_nxt        = in_delay_ticks;
      emit_cnt_nxt = '0;
    end else if (cmd.walk) begin
      idx_nxt = idx_r + CntW'(1);
      t_nxt   = t_r - cur_delta;
    end else if (cmd.step) begin
      idx_nxt = idx_r + CntW'(1);
    end
    if (cmd.pop) begin
      emit_cnt_nxt = emit_cnt_r + EmitW'(1);
    end
  end

  // Entry updates: insert with tail shift, decrement, head pop
  always_comb begin
    delta_nxt  = delta_r;
    handle_nxt = handle_r;
    count_nxt  = count_r;
    if (cmd.place) begin
      for (int j = 0; j < QueueDepth; j++) begin
        if (CntW'(j) == idx_r) begin
          delta_nxt[j]  = t_r;
          handle_nxt[j] = hnd_r;
        end else if (j > 0 && CntW'(j) > idx_r) begin
          delta_nxt[j]  = delta_r[j-1];
          handle_nxt[j] = handle_r[j-1];
          // Follower absorbs the remainder of the new entry's time
          if (CntW'(j) == idx_r + CntW'(1) && sts.idx_lt_cnt) begin
            delta_nxt[j] = delta_r[j-1] - t_r;
          end
        end
      end
      count_nxt = count_r + CntW'(1);
    end else if (cmd.dec) begin
      for (int j = 0; j < QueueDepth; j++) begin
        if (CntW'(j) == idx_r) begin
          delta_nxt[j] = delta_r[j] - DeltaW'(1);
        end
      end
    end else if (cmd.pop) begin
      for (int j = 0; j < QueueDepth - 1; j++) begin
        delta_nxt[j]  = delta_r[j+1];
        handle_nxt[j] = handle_r[j+1];
      end
      count_nxt = count_r - CntW'(1);
    end
  end

  // Output valid: set on emit, cleared once the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    delta_r  <= delta_nxt;
    handle_r <= handle_nxt;
    t_r      <= t_nxt;
    if (cmd.load) begin
      hnd_r     <= in_handle;
      blocked_r <= in_tick_blocked;
    end
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_handle_r <= (cmd.kind == KIND_EXPIRED) ? handle_r[0] : '0;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_expired_handle = out_handle_r;
  assign out_last           = out_last_r;

endmodule : dltq_datapath
`default_nettype wire

>>> rtl/core/delta_list_timeout_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_timeout_queue
// Sorted list of pending timeouts kept as relative delays, with insert,
// tick-driven expiry and a registered result channel.
// ----------------------------------------------------------------------------
// The queue takes one command at a time. An insert is accepted, walks past
// each entry whose delta fits its remaining time (up to 15), places the
// entry and hands over its result; an insert into a full table is accepted
// and hands over a full result. A tick is accepted, steps past the leading
// zero-delta entries (up to 16), decrements the first nonzero delta if any,
// then hands over one result per expired handle (or the single "nothing"
// result).
// The sequencer visits one list entry per cycle; a stalled result channel
// holds back each handover. A new command is taken as soon as the previous
// one has placed its last result in the output register.
// ----------------------------------------------------------------------------
module delta_list_timeout_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic                          in_tick_blocked,
  input  wire logic [dltq_pkg::DeltaW-1:0]   in_delay_ticks,
  input  wire logic [dltq_pkg::HandleW-1:0]  in_handle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dltq_pkg::KindW-1:0]         out_kind,
  output logic [dltq_pkg::HandleW-1:0]       out_expired_handle,
  output logic                               out_last
);
  import dltq_pkg::*;

  dltq_cmd_t dp_cmd;
  dltq_sts_t dp_sts;

  // Sequencer
  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // List storage and output register
  dltq_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tick_blocked    (in_tick_blocked),
    .in_delay_ticks     (in_delay_ticks),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_expired_handle (out_expired_handle),
    .out_last           (out_last),
    .cmd                (dp_cmd),
    .sts                (dp_sts)
  );

endmodule : delta_list_timeout_queue
`default_nettype wire
